// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the sequencer RTL; they compile to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ----- rtl/core/tdss_pkg.sv -----
// Types and constants shared by the table-driven step/delay sequencer.
`default_nettype none

package tdss_pkg;

   localparam logic [12:0] CYCLE_MAX = 13'd7000;

   typedef enum logic [1:0] {
      KIND_TICK    = 2'd0,
      KIND_SET_ALT = 2'd1,
      KIND_LOAD    = 2'd2,
      KIND_RESTART = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  entry_index;
      logic [14:0] entry_steps;
      logic [15:0] entry_delay;
      logic [3:0]  entry_next_primary;
      logic [3:0]  entry_next_alternate;
      logic [15:0] entry_cycle;
      logic        entry_has_action;
      logic        entry_has_delay_event;
   } req_type;

   typedef struct packed {
      logic               action_pulse;
      logic               delay_event_pulse;
      logic [12:0]        current_cycle;
      logic signed [15:0] current_steps;
   } rsp_type;

   // One stored table entry, 54 bits.
   typedef struct packed {
      logic [14:0] steps;
      logic [15:0] delay;
      logic [3:0]  next_primary;
      logic [3:0]  next_alternate;
      logic [12:0] cycle;
      logic        has_action;
      logic        has_delay_event;
   } entry_type;

   typedef struct packed {
      logic signed [15:0] steps;
      logic [15:0]        delay;
      logic [3:0]         next_primary;
      logic [3:0]         next_alternate;
      logic [12:0]        cycle;
      logic               has_action;
      logic               delay_event_pending;
      logic               alternate_flag;
   } work_type;

   typedef struct packed {
      logic       en;
      logic [3:0] index;
      entry_type  data;
   } wr_type;

endpackage

`default_nettype wire

// ----- rtl/core/tdss_ram.sv -----
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module tdss_ram #(
   parameter int unsigned WIDTH = 54,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

// ----- rtl/core/tdss_step.sv -----
// Next-state and result logic for one sequencer transaction.
`default_nettype none

module tdss_step import tdss_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  wire work_type  work_cur,
   input  wire req_type   req,
   input  wire entry_type entry_pri,
   input  wire entry_type entry_alt,
   input  wire entry_type entry_zero,
   output work_type       work_nxt,
   output rsp_type        rsp,
   output wr_type         wr
);

   function automatic work_type enter_entry(entry_type e);
      work_type w;
      w.steps               = $signed({1'b0, e.steps});
      w.delay               = e.delay;
      w.next_primary        = e.next_primary;
      w.next_alternate      = e.next_alternate;
      w.cycle               = e.cycle;
      w.has_action          = e.has_action;
      w.delay_event_pending = e.has_delay_event;
      w.alternate_flag      = 1'b0;
      return w;
   endfunction

   logic [3:0]  tgt;
   logic        tgt_ok;
   entry_type   tgt_entry;
   logic        act;
   logic        evt;
   logic [12:0] cycle_sat;

   always_comb begin
      tgt       = work_cur.alternate_flag ? work_cur.next_alternate : work_cur.next_primary;
      tgt_ok    = 32'(tgt) < TABLE_DEPTH;
      // A jump past the end of the table enters an all-zero entry.
      tgt_entry = tgt_ok ? (work_cur.alternate_flag ? entry_alt : entry_pri) : '0;
      cycle_sat = (req.entry_cycle > 16'(CYCLE_MAX)) ? CYCLE_MAX : req.entry_cycle[12:0];

      work_nxt = work_cur;
      act      = 1'b0;
      evt      = 1'b0;
      wr       = '0;

      unique case (req.kind)
         KIND_TICK: begin
            if (work_cur.steps > 16'sd0) begin
               act            = work_cur.has_action;
               work_nxt.steps = work_cur.steps - 16'sd1;
            end else if (work_cur.delay != 16'd0) begin
               work_nxt.delay = work_cur.delay - 16'd1;
               if (work_cur.delay == 16'd1 && work_cur.delay_event_pending) begin
                  evt                          = 1'b1;
                  work_nxt.delay_event_pending = 1'b0;
               end
            end else begin
               evt            = work_cur.delay_event_pending;
               work_nxt       = enter_entry(tgt_entry);
               act            = tgt_entry.has_action;
               work_nxt.steps = $signed({1'b0, tgt_entry.steps}) - 16'sd1;
            end
         end
         KIND_SET_ALT: begin
            work_nxt.alternate_flag = 1'b1;
         end
         KIND_LOAD: begin
            wr.en                  = 32'(req.entry_index) < TABLE_DEPTH;
            wr.index               = req.entry_index;
            wr.data.steps          = req.entry_steps;
            wr.data.delay          = req.entry_delay;
            wr.data.next_primary   = req.entry_next_primary;
            wr.data.next_alternate = req.entry_next_alternate;
            wr.data.cycle          = cycle_sat;
            wr.data.has_action     = req.entry_has_action;
            wr.data.has_delay_event = req.entry_has_delay_event;
         end
         KIND_RESTART: begin
            work_nxt = enter_entry(entry_zero);
         end
         default: begin
            work_nxt = work_cur;
         end
      endcase

      rsp.action_pulse      = act;
      rsp.delay_event_pulse = evt;
      rsp.current_cycle     = work_nxt.cycle;
      rsp.current_steps     = work_nxt.steps;
   end

endmodule

`default_nettype wire

// ----- rtl/core/table_driven_step_delay_sequencer.sv -----
// Top level of the table-driven step/delay sequencer.
//
//   Channel   Direction  Handshake                 Payload
//   req_*     in         req_valid / req_ready     req_payload (req_type)
//   rsp_*     out        rsp_valid / rsp_ready     rsp_payload (rsp_type)
//
// Every request transaction yields exactly one response transaction; it passes through the input
// register and then the response register. One transaction is accepted per cycle while the
// response side is not stalled; the step logic between the input register and the response
// register sets that figure. Reset is synchronous and clears the working state and the valid
// bits; the entry table is not cleared and holds garbage until loaded. A stall on rsp_ready
// backs up into the input register and then drops req_ready; no transaction is lost or repeated.
`default_nettype none
`include "assert_macros.svh"

module table_driven_step_delay_sequencer import tdss_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);

   // Input register. The step logic works on the transaction held here.
   logic    in_valid_ff, in_valid_in;
   req_type in_req_ff;

   // Response register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff;

   // Working copy of the current entry plus the pending and alternate flags.
   work_type work_ff, work_in, work_nxt;

   // The two possible jump targets are read from the table every cycle, addressed by the
   // next-entry fields that the working state will hold after this edge. When a load hits
   // one of those addresses in the same cycle, the RAM returns old data, so the written
   // entry is kept aside in a register and used instead.
   logic      byp_pri_ff, byp_pri_in;
   logic      byp_alt_ff, byp_alt_in;
   entry_type wdata_ff;

   // Entry 0 is mirrored in flops so that a restart does not need a third read port.
   entry_type zero_ff;

   logic          adv;
   logic          proc;
   wr_type        wr;
   rsp_type       rsp_nxt;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [AW-1:0] raddr_pri;
   logic [AW-1:0] raddr_alt;
   logic [$bits(entry_type)-1:0] rdata_pri;
   logic [$bits(entry_type)-1:0] rdata_alt;
   entry_type     entry_pri;
   entry_type     entry_alt;

   // The response register frees up when it is empty or being emptied.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign proc      = in_valid_ff && adv;
   assign req_ready = !in_valid_ff || adv;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = proc ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign work_in      = proc ? work_nxt : work_ff;

   assign ram_we    = proc && wr.en;
   assign ram_waddr = AW'(wr.index);
   assign raddr_pri = AW'(work_in.next_primary);
   assign raddr_alt = AW'(work_in.next_alternate);

   assign byp_pri_in = ram_we && (ram_waddr == raddr_pri);
   assign byp_alt_in = ram_we && (ram_waddr == raddr_alt);

   assign entry_pri = byp_pri_ff ? wdata_ff : entry_type'(rdata_pri);
   assign entry_alt = byp_alt_ff ? wdata_ff : entry_type'(rdata_alt);

   tdss_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (wr.data),
      .rd_addr_a (raddr_pri),
      .rd_addr_b (raddr_alt),
      .rd_data_a (rdata_pri),
      .rd_data_b (rdata_alt)
   );

   tdss_step #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_step (
      .work_cur   (work_ff),
      .req        (in_req_ff),
      .entry_pri  (entry_pri),
      .entry_alt  (entry_alt),
      .entry_zero (zero_ff),
      .work_nxt   (work_nxt),
      .rsp        (rsp_nxt),
      .wr         (wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         work_ff      <= '0;
         byp_pri_ff   <= 1'b0;
         byp_alt_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         work_ff      <= work_in;
         byp_pri_ff   <= byp_pri_in;
         byp_alt_ff   <= byp_alt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff <= req_payload;
      end
      if (proc) begin
         rsp_payload_ff <= rsp_nxt;
      end
      wdata_ff <= wr.data;
      if (ram_we && wr.index == 4'd0) begin
         zero_ff <= wr.data;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The step count only ever falls to minus one, by a jump into an entry with no steps.
   `ASSERT_NEVER(a_steps_floor, clock, reset, work_ff.steps < -16'sd1, "step count below minus one")
   // A restart always leaves the alternate flag clear.
   `ASSERT_PROP(a_restart_alt, clock, reset, proc && in_req_ff.kind == KIND_RESTART |=> !work_ff.alternate_flag, "alternate flag survived a restart")
   // Stored cycle values are saturated, so a response never shows more than the limit.
   `ASSERT_NEVER(a_cycle_sat, clock, reset, rsp_valid_ff && rsp_payload_ff.current_cycle > CYCLE_MAX, "response cycle above limit")
   // Requests are only held off while a response is stalled.
   `ASSERT_NEVER(a_false_stall, clock, reset, !req_ready && !(rsp_valid_ff && !rsp_ready), "request stalled without a response stall")

endmodule

`default_nettype wire
